[sv/ila_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ila_pkg
// Shared sizes, codes and types of the indexed list block.
// ----------------------------------------------------------------------------
package ila_pkg;

  localparam int DEPTH    = 16;
  localparam int VALUE_W  = 32;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int LEN_W    = $clog2(DEPTH + 1);

  // fixed field widths of the channels
  localparam int MODE_W   = 3;
  localparam int INDEX_W  = 5;
  localparam int IN_VAL_W = 32;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 4;
  localparam int ELEM_W   = 32;
  localparam int MATCH_W  = 5;
  localparam int OUT_LEN_W = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 3'd0,
    MODE_INSERT = 3'd1,
    MODE_DELETE = 3'd2,
    MODE_SEARCH = 3'd3,
    MODE_COUNT  = 3'd4,
    MODE_LIST   = 3'd5
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_INDEX = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    SH_NONE,
    SH_UP,
    SH_DOWN
  } shift_e;

  // broadcast to every cell
  typedef struct packed {
    shift_e              shift;
    logic [LEN_W-1:0]    lo;
    logic [LEN_W-1:0]    hi;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_pos;
    logic [VALUE_W-1:0]  wr_data;
    logic [VALUE_W-1:0]  key;
  } cell_cmd_t;

  typedef struct packed {
    status_e              status;
    logic [POS_W-1:0]     position;
    logic [ELEM_W-1:0]    element;
    logic [MATCH_W-1:0]   matches_res;
    logic [OUT_LEN_W-1:0] length;
    logic                 last;
  } result_t;

endpackage

[sv/ila_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ila_in_if
// Request channel: operation code, index and value with valid/ready.
// ----------------------------------------------------------------------------
interface ila_in_if import ila_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [INDEX_W-1:0]  index;
  logic [IN_VAL_W-1:0] value;

  modport source (output valid, output mode, output index, output value, input ready);
  modport sink   (input valid, input mode, input index, input value, output ready);
endinterface

[sv/ila_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ila_out_if
// Result channel: status, position, element, match count, length, last flag.
// ----------------------------------------------------------------------------
interface ila_out_if import ila_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [POS_W-1:0]     position;
  logic [ELEM_W-1:0]    element;
  logic [MATCH_W-1:0]   matches_res;
  logic [OUT_LEN_W-1:0] length;
  logic                 last;

  modport source (output valid, output status, output position, output element,
                  output matches_res, output length, output last, input ready);
  modport sink   (input valid, input status, input position, input element,
                  input matches_res, input length, input last, output ready);
endinterface

[sv/ila_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ila_cell
// One list slot: holds an entry, loads from either neighbor or the write bus,
// and registers its compare against the broadcast key.
// ----------------------------------------------------------------------------
module ila_cell import ila_pkg::*; (
  input  logic               clk_i,
  input  cell_cmd_t          cmd_i,
  input  logic [IDX_W-1:0]   pos_i,
  input  logic [VALUE_W-1:0] left_i,
  input  logic [VALUE_W-1:0] right_i,
  output logic [VALUE_W-1:0] entry_o,
  output logic               match_o
);

  logic [VALUE_W-1:0] entry_q, entry_d;
  logic               match_q;
  logic [LEN_W-1:0]   pos_l;

  assign pos_l = LEN_W'(pos_i);

  always_comb begin
    priority if (cmd_i.wr_en && (pos_i == cmd_i.wr_pos)) begin
      entry_d = cmd_i.wr_data;
    end else if ((cmd_i.shift == SH_UP) && (pos_l > cmd_i.lo) && (pos_l <= cmd_i.hi)) begin
      entry_d = left_i;
    end else if ((cmd_i.shift == SH_DOWN) && (pos_l >= cmd_i.lo) && (pos_l < cmd_i.hi)) begin
      entry_d = right_i;
    end else begin
      entry_d = entry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    match_q <= (entry_q == cmd_i.key);
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

[sv/indexed_list_insert_delete.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_delete
// Ordered list of up to DEPTH signed values held in a row of cells.
// ----------------------------------------------------------------------------
// Requests come in on in_i (mode, index, value), results leave on out_o,
// both valid/ready. One request is worked on at a time; in_i.ready is high
// only while the block is idle.
// Append, insert, delete and unused modes: the request is latched, then
// every cell shifts or loads at once as the result is registered.
// Search and count: after latching, each cell registers its compare, then
// the match vector is reduced by a priority encoder and a bit count.
// List: the row rotates one slot per cycle toward cell 0 while the output
// is free; cell 0 drives the result, so an n-entry list gives n results
// and ends in its original order. Empty list gives one status result.
// Results sit in one output register; a stalled receiver holds the block in
// its current step and nothing is lost. A new request can be taken in the
// cycle after the last result is registered, even if it is still waiting.
// Reset empties the list (length 0); entry contents are not cleared.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete import ila_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ila_in_if.sink     in_i,
  ila_out_if.source  out_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REDUCE,
    S_LIST
  } state_e;

  state_e              state_q, state_d;
  logic [MODE_W-1:0]   mode_q, mode_d;
  logic [INDEX_W-1:0]  idx_q, idx_d;
  logic [VALUE_W-1:0]  key_q, key_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic [IDX_W-1:0]    cnt_q, cnt_d;
  result_t             out_q, out_d;
  logic                out_valid_q, out_valid_d;

  cell_cmd_t           cmd;
  logic [VALUE_W-1:0]  entry_w [DEPTH];
  logic [DEPTH-1:0]    match_w;
  logic [DEPTH-1:0]    live_mask;
  logic [DEPTH-1:0]    hit;
  logic                found;
  logic [POS_W-1:0]    first_pos;
  logic [MATCH_W-1:0]  hit_count;
  logic                out_free;
  logic                list_last;

  // ---- row of cells ----
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VALUE_W-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = entry_w[g-1];
    end
    if (g == DEPTH - 1) begin : g_final
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = entry_w[g+1];
    end
    ila_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .pos_i   (IDX_W'(g)),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (entry_w[g]),
      .match_o (match_w[g])
    );
  end

  // ---- match reduction ----
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      live_mask[i] = (LEN_W'(i) < len_q);
    end
    hit       = match_w & live_mask;
    found     = |hit;
    first_pos = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (hit[i]) begin
        first_pos = POS_W'(i);
      end
    end
    hit_count = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_count = hit_count + MATCH_W'(hit[i]);
    end
  end

  assign out_free  = !out_valid_q || out_o.ready;
  assign list_last = ((32'(cnt_q) + 32'd1) == 32'(len_q));

  // ---- control ----
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    idx_d       = idx_q;
    key_d       = key_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;

    cmd         = '0;
    cmd.shift   = SH_NONE;
    cmd.key     = key_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          mode_d  = in_i.mode;
          idx_d   = in_i.index;
          key_d   = VALUE_W'($signed(in_i.value));
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        if (out_free) begin
          out_d   = '{status: ST_OK, position: '0, element: '0, matches_res: '0,
                      length: '0, last: 1'b1};
          state_d = S_IDLE;
          unique case (mode_e'(mode_q))
            MODE_APPEND: begin
              if (32'(len_q) >= DEPTH) begin
                out_d.status = ST_FULL;
              end else begin
                cmd.wr_en   = 1'b1;
                cmd.wr_pos  = IDX_W'(len_q);
                cmd.wr_data = key_q;
                len_d       = LEN_W'(32'(len_q) + 32'd1);
              end
            end
            MODE_INSERT: begin
              if (32'(idx_q) > 32'(len_q)) begin
                out_d.status = ST_BAD_INDEX;
              end else if (32'(len_q) >= DEPTH) begin
                out_d.status = ST_FULL;
              end else begin
                cmd.shift   = SH_UP;
                cmd.lo      = LEN_W'(idx_q);
                cmd.hi      = len_q;
                cmd.wr_en   = 1'b1;
                cmd.wr_pos  = IDX_W'(idx_q);
                cmd.wr_data = key_q;
                len_d       = LEN_W'(32'(len_q) + 32'd1);
              end
            end
            MODE_DELETE: begin
              if (len_q == '0) begin
                out_d.status = ST_EMPTY;
              end else if (32'(idx_q) >= 32'(len_q)) begin
                out_d.status = ST_BAD_INDEX;
              end else begin
                cmd.shift = SH_DOWN;
                cmd.lo    = LEN_W'(idx_q);
                cmd.hi    = LEN_W'(32'(len_q) - 32'd1);
                len_d     = LEN_W'(32'(len_q) - 32'd1);
              end
            end
            MODE_SEARCH, MODE_COUNT: begin
              // cells register their compares this cycle
              out_d   = out_q;
              state_d = S_REDUCE;
            end
            MODE_LIST: begin
              if (len_q == '0) begin
                out_d.status = ST_EMPTY;
              end else begin
                out_d   = out_q;
                cnt_d   = '0;
                state_d = S_LIST;
              end
            end
            default: begin
            end
          endcase
          if (state_d == S_IDLE) begin
            out_d.length = OUT_LEN_W'(len_d);
            out_valid_d  = 1'b1;
          end
        end
      end

      S_REDUCE: begin
        if (out_free) begin
          out_d = '{status: ST_OK, position: '0, element: '0, matches_res: '0,
                    length: OUT_LEN_W'(len_q), last: 1'b1};
          if (mode_e'(mode_q) == MODE_SEARCH) begin
            if (found) begin
              out_d.position = first_pos;
            end else begin
              out_d.status = ST_NOT_FOUND;
            end
          end else begin
            out_d.matches_res = hit_count;
          end
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      S_LIST: begin
        if (out_free) begin
          out_d = '{status: ST_OK, position: POS_W'(cnt_q),
                    element: ELEM_W'(entry_w[0]), matches_res: '0,
                    length: OUT_LEN_W'(len_q), last: list_last};
          out_valid_d = 1'b1;
          // rotate: cell 0 wraps to the tail, the rest move down
          cmd.shift   = SH_DOWN;
          cmd.lo      = '0;
          cmd.hi      = LEN_W'(32'(len_q) - 32'd1);
          cmd.wr_en   = 1'b1;
          cmd.wr_pos  = IDX_W'(32'(len_q) - 32'd1);
          cmd.wr_data = entry_w[0];
          cnt_d       = IDX_W'(32'(cnt_q) + 32'd1);
          if (list_last) begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      mode_q      <= '0;
      idx_q       <= '0;
      key_q       <= '0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      mode_q      <= mode_d;
      idx_q       <= idx_d;
      key_q       <= key_d;
      out_q       <= out_d;
    end
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_q.status;
  assign out_o.position    = out_q.position;
  assign out_o.element     = out_q.element;
  assign out_o.matches_res = out_q.matches_res;
  assign out_o.length      = out_q.length;
  assign out_o.last        = out_q.last;

  // ---- checks ----
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(len_q) <= DEPTH)
    else $error("list length above depth");

  a_len_only_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q != $past(len_q)) |-> ($past(state_q) == S_EXEC))
    else $error("length changed outside an update step");

  a_list_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LIST && out_free && list_last) |=> (state_q == S_IDLE && out_o.last))
    else $error("list run did not end on its last item");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == S_EXEC))
    else $error("accepted item did not start execution");

endmodule
